@@ hw/rtl/tcc_pkg.sv @@
// Shared constants, command/status structs and controller states for the
// trimmed charge centroid block. Depends on nothing; all but tcc_ram import it.
package tcc_pkg;

    // Block dimensions.
    localparam int MAX_STRIPS  = 16;
    localparam int CHARGE_BITS = 8;
    localparam int POS_W       = 10;
    localparam int TRIM_W      = 9;
    localparam int CENT_W      = 18;
    localparam int USED_W      = 5;

    // Derived widths.
    localparam int ADDR_W    = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1;
    localparam int COUNT_W   = $clog2(MAX_STRIPS + 1);
    localparam int ENTRY_W   = POS_W + CHARGE_BITS;
    localparam int PROD_W    = TRIM_W + CHARGE_BITS;
    localparam int MUL_W     = CHARGE_BITS + POS_W;
    localparam int MOM_W     = CHARGE_BITS + POS_W + $clog2(MAX_STRIPS);
    localparam int TOT_W     = CHARGE_BITS + $clog2(MAX_STRIPS);
    localparam int FRAC_W    = 8;
    localparam int DIV_W     = MOM_W + FRAC_W;
    localparam int DIVCNT_W  = $clog2(DIV_W + 1);

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_FIELDS_W = POS_W + CHARGE_BITS;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = CENT_W + USED_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TRIM_W;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_FRACTION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_MODE = 1'd1;

    // Position mode codes.
    localparam logic MODE_STRIP_NUMBER = 1'b0;
    localparam logic MODE_INDEX        = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        S_LOAD,
        S_THRESH,
        S_PASS,
        S_DIV_INIT,
        S_DIV,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_strip;
        logic start_pass;
        logic issue_read;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic issue_done;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

@@ hw/rtl/tcc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the strip store; depends on nothing.
module tcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hw/rtl/tcc_datapath.sv @@
// Datapath of the trimmed charge centroid: strip store, peak and threshold,
// accumulation pass, serial divider and output register. Uses tcc_pkg, tcc_ram.
module tcc_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tcc_pkg::t_dp_cmd               i_cmd,
    output tcc_pkg::t_dp_status            o_status,
    input  logic [tcc_pkg::POS_W-1:0]      i_strip_number,
    input  logic [tcc_pkg::CHARGE_BITS-1:0] i_charge,
    input  logic                           i_cfg_we,
    input  logic [tcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_m_ready,
    output logic                           o_out_valid,
    output logic [tcc_pkg::CENT_W-1:0]     o_centroid,
    output logic [tcc_pkg::USED_W-1:0]     o_strips_used,
    output logic                           o_valid_res,
    output logic                           o_overflow
);
    import tcc_pkg::*;

    // Configuration registers.
    logic [TRIM_W-1:0] r_trim;
    logic              r_mode;

    // Cluster state.
    logic [COUNT_W-1:0]     r_count;
    logic [CHARGE_BITS-1:0] r_peak;
    logic                   r_ovf_flag;
    logic [PROD_W-1:0]      r_prod;

    // Pass state.
    logic [COUNT_W-1:0] r_idx;
    logic [COUNT_W-1:0] r_rd_idx;
    logic               r_rd_v;
    logic [MOM_W-1:0]   r_moment;
    logic [TOT_W-1:0]   r_total;
    logic [COUNT_W-1:0] r_used;

    // Divider state.
    logic [DIV_W-1:0]    r_quo;
    logic [TOT_W-1:0]    r_rem;
    logic [DIVCNT_W-1:0] r_div_cnt;

    // Output register.
    logic              r_out_valid;
    logic [CENT_W-1:0] r_cent;
    logic [USED_W-1:0] r_used_out;
    logic              r_vres;
    logic              r_ovf_out;

    logic                   store_full;
    logic                   we;
    logic [ENTRY_W-1:0]     rdata;
    logic [CHARGE_BITS-1:0] rd_charge;
    logic [POS_W-1:0]       rd_pos;
    logic [POS_W-1:0]       pos_sel;
    logic                   keep;
    logic [MUL_W-1:0]       weight;
    logic [TOT_W:0]         rem_sh;
    logic [TOT_W:0]         rem_diff;
    logic                   rem_ge;

    assign store_full = (r_count == COUNT_W'(MAX_STRIPS));
    assign we         = i_cmd.load_strip && !store_full;

    // Strip store: charge in the low bits, strip number above.
    tcc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_STRIPS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({i_strip_number, i_charge}),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    assign rd_charge = rdata[CHARGE_BITS-1:0];
    assign rd_pos    = rdata[ENTRY_W-1:CHARGE_BITS];

    // Keep decision and weighted position of the strip read back this cycle.
    always_comb begin
        if (r_mode == MODE_STRIP_NUMBER) begin
            keep    = {rd_charge, {FRAC_W{1'b0}}} >= {1'b0, r_prod};
            pos_sel = rd_pos;
        end else begin
            keep    = {1'b0, rd_charge} >= r_prod[PROD_W-1:FRAC_W];
            pos_sel = POS_W'(r_rd_idx);
        end
        weight = MUL_W'(rd_charge) * MUL_W'(pos_sel);
    end

    // One restoring division step.
    always_comb begin
        rem_sh   = {r_rem, r_quo[DIV_W-1]};
        rem_diff = rem_sh - {1'b0, r_total};
        rem_ge   = (rem_sh >= {1'b0, r_total});
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim <= '0;
            r_mode <= MODE_STRIP_NUMBER;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRIM_FRACTION: r_trim <= i_cfg_data;
                CFG_POSITION_MODE: r_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Strip loading, peak tracking and cluster clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_peak     <= '0;
            r_ovf_flag <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_count    <= '0;
            r_peak     <= '0;
            r_ovf_flag <= 1'b0;
        end else if (i_cmd.load_strip) begin
            if (store_full) begin
                r_ovf_flag <= 1'b1;
            end else begin
                r_count <= r_count + 1'b1;
                if (i_charge > r_peak) begin
                    r_peak <= i_charge;
                end
            end
        end
    end

    // Threshold product, taken once the cluster is complete.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_pass) begin
            r_prod <= PROD_W'(r_trim) * PROD_W'(r_peak);
        end
    end

    // Read sequencing for the accumulation pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.issue_read;
            if (i_cmd.start_pass) begin
                r_idx <= '0;
            end else if (i_cmd.issue_read) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue_read) begin
            r_rd_idx <= r_idx;
        end
    end

    // Accumulate moment, total charge and count of kept strips.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_pass) begin
            r_moment <= '0;
            r_total  <= '0;
            r_used   <= '0;
        end else if (r_rd_v && keep) begin
            r_moment <= r_moment + MOM_W'(weight);
            r_total  <= r_total + TOT_W'(rd_charge);
            r_used   <= r_used + 1'b1;
        end
    end

    // Serial divider: one quotient bit per step, MSB first.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo     <= {r_moment, {FRAC_W{1'b0}}};
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo     <= {r_quo[DIV_W-2:0], rem_ge};
            r_rem     <= rem_ge ? rem_diff[TOT_W-1:0] : rem_sh[TOT_W-1:0];
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    // Output register; a new result may load as the previous beat leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_cent     <= (r_total != '0) ? r_quo[CENT_W-1:0] : '0;
            r_used_out <= USED_W'(r_used);
            r_vres     <= (r_total != '0);
            r_ovf_out  <= r_ovf_flag;
        end
    end

    assign o_status.issue_done = (r_idx == r_count);
    assign o_status.div_done   = (r_div_cnt == DIVCNT_W'(DIV_W));
    assign o_status.out_free   = !r_out_valid || i_m_ready;

    assign o_out_valid   = r_out_valid;
    assign o_centroid    = r_cent;
    assign o_strips_used = r_used_out;
    assign o_valid_res   = r_vres;
    assign o_overflow    = r_ovf_out;

endmodule

@@ hw/rtl/tcc_ctrl.sv @@
// Controller of the trimmed charge centroid: sequences loading, the store pass,
// the divider and the result hand-off. Uses tcc_pkg.
module tcc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_valid,
    input  logic                 i_s_last,
    output logic                 o_s_ready,
    input  tcc_pkg::t_dp_status  i_status,
    output tcc_pkg::t_dp_cmd     o_cmd
);
    import tcc_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_s_ready        = 1'b1;
                o_cmd.load_strip = i_s_valid;
                if (i_s_valid && i_s_last) begin
                    n_state = S_THRESH;
                end
            end
            S_THRESH: begin
                o_cmd.start_pass = 1'b1;
                n_state          = S_PASS;
            end
            S_PASS: begin
                if (i_status.issue_done) begin
                    n_state = S_DIV_INIT;
                end else begin
                    o_cmd.issue_read = 1'b1;
                end
            end
            S_DIV_INIT: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

@@ hw/rtl/trimmed_charge_centroid_top.sv @@
// Top level of the trimmed charge centroid block.
// Depends on tcc_pkg, tcc_ctrl, tcc_datapath and tcc_ram.
//
// Usage: strips of one cluster arrive on the slave stream, one beat per strip,
// with tlast on the final strip. While loading, the block is ready for every
// strip beat. After the last strip the block stops accepting beats, computes
// the threshold, passes over the N stored strips, sets up the divider, runs
// MOM_W + 8 = 30 restoring division steps, sees the step count finish and
// loads the result into the output register. The division steps take most
// of the time spent after the last strip.
// The result beat appears on the master stream in the cycle after that load.
// While a result waits in the output register the next cluster is loaded;
// a stalled receiver only holds the next result back in its final state.
// Strips beyond the store depth are dropped and reported as overflow.
// Reset (synchronous, active low) empties the cluster, clears the output
// valid flag and sets both configuration registers to zero. Configuration is
// written through the plain write port; the user must write it only while
// no cluster is in progress, since the block itself does not enforce this.
module trimmed_charge_centroid_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Slave stream: strip beats.
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata: strip_number [9:0], charge [17:10], zero pad above.
    input  logic [tcc_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    // tlast: last_strip.
    input  logic                               i_s_axis_tlast,
    // Master stream: result beats.
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata: centroid [17:0], strips_used [22:18], zero pad above.
    output logic [tcc_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    // tuser: valid_res [0], overflow [1].
    output logic [tcc_pkg::M_TUSER_W-1:0]      o_m_axis_tuser,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [tcc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tcc_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    logic [POS_W-1:0]       strip_number;
    logic [CHARGE_BITS-1:0] charge;
    logic [CENT_W-1:0]      centroid;
    logic [USED_W-1:0]      strips_used;
    logic                   valid_res;
    logic                   overflow;

    // Unpack the strip beat.
    assign strip_number = i_s_axis_tdata[POS_W-1:0];
    assign charge       = i_s_axis_tdata[POS_W+CHARGE_BITS-1:POS_W];

    tcc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_s_last  (i_s_axis_tlast),
        .o_s_ready (o_s_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    tcc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_strip_number (strip_number),
        .i_charge       (charge),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_m_ready      (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_centroid     (centroid),
        .o_strips_used  (strips_used),
        .o_valid_res    (valid_res),
        .o_overflow     (overflow)
    );

    // Pack the result beat.
    assign o_m_axis_tdata = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, strips_used, centroid};
    assign o_m_axis_tuser = {overflow, valid_res};

endmodule

@@ verif/tb_trimmed_charge_centroid_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for trimmed_charge_centroid_top: strip beats in, centroid beats out.
// Depends on tcc_pkg and the block's RTL; an internal cluster model predicts untyped results.
module tb_trimmed_charge_centroid_top;
    import tcc_pkg::*;

    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int SETTLE_CYCLES    = 64;
    localparam int HOLD_CYCLES      = 500;
    localparam int NUM_PHASES       = 8;
    localparam int ITEMS_PER_PHASE  = 85;

    // One result beat, unpacked from tdata and tuser.
    typedef struct packed {
        logic [CENT_W-1:0] centroid;
        logic [USED_W-1:0] used;
        logic              valid;
        logic              ovf;
    } t_cluster_result;

    typedef enum logic {ROW_WRITE, ROW_STRIP} t_row_kind;

    // One line of the directed table: a register write or a run of strips.
    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] value;
        logic [POS_W-1:0]      pos;
        logic [CHARGE_BITS-1:0] q;
        logic                  last;
        logic [4:0]            repeat_n;
        logic                  typed;
        t_cluster_result       want;
    } t_stim_row;

    localparam t_cluster_result NO_RESULT = '0;

    localparam t_stim_row DIRECTED_ROWS [18] = '{
        // Reset settings: one strip at the top of both fields, then a zero-charge strip.
        '{ROW_STRIP, 1'b0, 9'd0, 10'd1023, 8'd255, 1'b1, 5'd1, 1'b1,
          '{18'd261888, 5'd1, 1'b1, 1'b0}},
        '{ROW_STRIP, 1'b0, 9'd0, 10'd0, 8'd0, 1'b1, 5'd1, 1'b1,
          '{18'd0, 5'd1, 1'b0, 1'b0}},
        // Trim of exactly 1.0 keeps only the peak strip.
        '{ROW_WRITE, CFG_TRIM_FRACTION, 9'd256, 10'd0, 8'd0, 1'b0, 5'd0, 1'b0, NO_RESULT},
        '{ROW_STRIP, 1'b0, 9'd0, 10'd3, 8'd200, 1'b0, 5'd1, 1'b0, NO_RESULT},
        '{ROW_STRIP, 1'b0, 9'd0, 10'd9, 8'd255, 1'b1, 5'd1, 1'b1,
          '{18'd2304, 5'd1, 1'b1, 1'b0}},
        // Trim above 1.0 rejects every strip in both modes.
        '{ROW_WRITE, CFG_TRIM_FRACTION, 9'd511, 10'd0, 8'd0, 1'b0, 5'd0, 1'b0, NO_RESULT},
        '{ROW_STRIP, 1'b0, 9'd0, 10'd50, 8'd40, 1'b1, 5'd1, 1'b1, NO_RESULT},
        '{ROW_WRITE, CFG_POSITION_MODE, 9'h001, 10'd0, 8'd0, 1'b0, 5'd0, 1'b0, NO_RESULT},
        '{ROW_STRIP, 1'b0, 9'd0, 10'd600, 8'd40, 1'b1, 5'd1, 1'b1, NO_RESULT},
        // Index mode with a half trim and a strip sitting right at the threshold.
        '{ROW_WRITE, CFG_TRIM_FRACTION, 9'd128, 10'd0, 8'd0, 1'b0, 5'd0, 1'b0, NO_RESULT},
        '{ROW_STRIP, 1'b0, 9'd0, 10'd7, 8'd255, 1'b0, 5'd1, 1'b0, NO_RESULT},
        '{ROW_STRIP, 1'b0, 9'd0, 10'd8, 8'd0, 1'b0, 5'd1, 1'b0, NO_RESULT},
        '{ROW_STRIP, 1'b0, 9'd0, 10'd9, 8'd127, 1'b0, 5'd1, 1'b0, NO_RESULT},
        '{ROW_STRIP, 1'b0, 9'd0, 10'd10, 8'd128, 1'b1, 5'd1, 1'b0, NO_RESULT},
        // Back to strip-number mode; only the low bit of the mode write counts.
        '{ROW_WRITE, CFG_TRIM_FRACTION, 9'd0, 10'd0, 8'd0, 1'b0, 5'd0, 1'b0, NO_RESULT},
        '{ROW_WRITE, CFG_POSITION_MODE, 9'h1FE, 10'd0, 8'd0, 1'b0, 5'd0, 1'b0, NO_RESULT},
        // A full store, then a last strip that is dropped but still closes the cluster.
        '{ROW_STRIP, 1'b0, 9'd0, 10'd0, 8'd2, 1'b0, 5'd16, 1'b0, NO_RESULT},
        '{ROW_STRIP, 1'b0, 9'd0, 10'd1000, 8'd255, 1'b1, 5'd1, 1'b1,
          '{18'd1920, 5'd16, 1'b1, 1'b1}}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [S_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic                   i_s_axis_tlast = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_axis_tdata;
    logic [M_TUSER_W-1:0]   o_m_axis_tuser;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Cluster model state and its copy of the registers.
    logic [CHARGE_BITS-1:0] held_q   [MAX_STRIPS];
    logic [POS_W-1:0]       held_pos [MAX_STRIPS];
    int unsigned            held_count = 0;
    logic [CHARGE_BITS-1:0] peak_q = '0;
    logic                   ovf_seen = 1'b0;
    logic [TRIM_W-1:0]      trim_shadow = '0;
    logic                   mode_shadow = MODE_STRIP_NUMBER;

    t_cluster_result        cluster_results_due [$];
    int unsigned            mismatch_count = 0;
    int unsigned            results_seen = 0;
    int unsigned            strips_sent = 0;
    bit                     tx_no_gaps = 1'b0;
    bit                     rx_hold_wanted = 1'b0;

    trimmed_charge_centroid_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic flag_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        mismatch_count++;
    endtask

    // Adds one strip to the modeled cluster; on the last strip it returns 1 with the
    // trimmed centroid and clears the cluster.
    function automatic bit fold_strip(input logic [POS_W-1:0] pos,
                                      input logic [CHARGE_BITS-1:0] q, input logic last,
                                      output t_cluster_result res);
        logic [63:0] moment;
        logic [63:0] total;
        logic [63:0] trim_prod;
        logic [63:0] c;
        logic [63:0] p;
        logic [63:0] cent;
        int unsigned used;
        bit          keep;
        moment = '0;
        total = '0;
        cent = '0;
        used = 0;
        res = '0;
        if (held_count < MAX_STRIPS) begin
            held_q[held_count] = q;
            held_pos[held_count] = pos;
            held_count++;
            if (q > peak_q) peak_q = q;
        end else begin
            ovf_seen = 1'b1;
        end
        if (!last) return 1'b0;

        trim_prod = 64'(trim_shadow) * 64'(peak_q);
        for (int i = 0; i < held_count; i++) begin
            c = 64'(held_q[i]);
            if (mode_shadow == MODE_STRIP_NUMBER) begin
                keep = (c << 8) >= trim_prod;
                p = 64'(held_pos[i]);
            end else begin
                keep = c >= (trim_prod >> 8);
                p = 64'(i);
            end
            if (keep) begin
                moment += c * p;
                total += c;
                used++;
            end
        end
        if (total != 0) cent = (moment << 8) / total;

        res.centroid = cent[CENT_W-1:0];
        res.used = used[USED_W-1:0];
        res.valid = (total != 0);
        res.ovf = ovf_seen;
        held_count = 0;
        peak_q = '0;
        ovf_seen = 1'b0;
        return 1'b1;
    endfunction

    // Offers one strip beat after an optional gap; once taken, queues any expected result.
    task automatic send_strip(input logic [POS_W-1:0] pos, input logic [CHARGE_BITS-1:0] q,
                              input logic last, input logic typed,
                              input t_cluster_result want);
        logic [S_TDATA_W-1:0] beat;
        t_cluster_result      forecast;
        int unsigned          gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        beat = '0;
        beat[POS_W-1:0] = pos;
        beat[POS_W +: CHARGE_BITS] = q;
        i_s_axis_tdata <= beat;
        i_s_axis_tlast <= last;
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (fold_strip(pos, q, last, forecast))
            cluster_results_due.push_back(typed ? want : forecast);
        strips_sent++;
    endtask

    // Register writes happen only with the block drained and settled.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_s_axis_tvalid <= 1'b0;
        while (cluster_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_TRIM_FRACTION) trim_shadow = data;
        else mode_shadow = data[0];
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One random cluster; about one in eight overruns the store.
    task automatic send_random_cluster();
        int unsigned            len;
        int unsigned            style;
        logic [POS_W-1:0]       pos;
        logic [CHARGE_BITS-1:0] q;
        bit                     contiguous;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_STRIPS + 1, MAX_STRIPS + 4)
                                          : $urandom_range(1, MAX_STRIPS);
        style = $urandom_range(0, 5);
        pos = 10'($urandom_range(0, 1023));
        contiguous = ($urandom_range(0, 3) != 0);
        for (int k = 0; k < len; k++) begin
            case (style)
                0, 1: q = 8'($urandom_range(0, 255));
                2: q = 8'($urandom_range(0, 3));
                3: q = 8'($urandom_range(192, 255));
                4: q = (k == len / 2) ? 8'd255 : 8'($urandom_range(0, 255));
                default: q = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
            endcase
            send_strip(pos, q, k == len - 1, 1'b0, NO_RESULT);
            pos = contiguous ? pos + 1'b1 : 10'($urandom_range(0, 1023));
        end
    endtask

    // Stimulus: directed table, then random phases with a fresh setting each.
    initial begin : stimulus
        t_stim_row         row;
        logic [TRIM_W-1:0] trim_pick;
        logic [CFG_DATA_W-1:0] mode_data;
        int unsigned       phase_start;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[r]) begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_WRITE) begin
                write_reg(row.reg_index, row.value);
            end else begin
                for (int k = 0; k < row.repeat_n; k++)
                    send_strip(row.pos + k[POS_W-1:0], row.q,
                               row.last && (k == row.repeat_n - 1), row.typed, row.want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: trim_pick = 9'($urandom_range(0, 511));
                1, 4: trim_pick = 9'd256;
                2, 5: trim_pick = 9'd0;
                3: trim_pick = 9'd511;
                default: trim_pick = 9'($urandom_range(0, 256));
            endcase
            mode_data = 9'($urandom_range(0, 511));
            mode_data[0] = ph[0];
            write_reg(CFG_TRIM_FRACTION, trim_pick);
            write_reg(CFG_POSITION_MODE, mode_data);
            // Phase 1 streams with no gaps while the result side is held off.
            if (ph == 1) begin
                tx_no_gaps = 1'b1;
                rx_hold_wanted = 1'b1;
            end
            phase_start = strips_sent;
            while (strips_sent - phase_start < ITEMS_PER_PHASE) begin
                if (ph != 1) tx_no_gaps = ($urandom_range(0, 3) == 0);
                send_random_cluster();
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (cluster_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result side: random ready gaps, quiet stretches, and one long hold-off.
    initial begin : result_sink
        int unsigned gap;
        int unsigned taken;
        bit          no_gaps;
        taken = 0;
        no_gaps = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_wanted) begin
                gap = HOLD_CYCLES;
                rx_hold_wanted = 1'b0;
            end else begin
                gap = no_gaps ? 0 : $urandom_range(0, 13);
            end
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            taken++;
            if (taken % 8 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        end
    end

    // Each result beat is checked field by field against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_cluster_result want;
        t_cluster_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.centroid = o_m_axis_tdata[CENT_W-1:0];
            got.used = o_m_axis_tdata[CENT_W +: USED_W];
            got.valid = o_m_axis_tuser[0];
            got.ovf = o_m_axis_tuser[1];
            if (cluster_results_due.size() == 0) begin
                flag_mismatch("result beat with no cluster pending");
            end else begin
                want = cluster_results_due.pop_front();
                if (got.centroid !== want.centroid)
                    flag_mismatch($sformatf("centroid got %0d want %0d",
                                            got.centroid, want.centroid));
                if (got.used !== want.used)
                    flag_mismatch($sformatf("strips_used got %0d want %0d",
                                            got.used, want.used));
                if (got.valid !== want.valid)
                    flag_mismatch($sformatf("valid_res got %0b want %0b",
                                            got.valid, want.valid));
                if (got.ovf !== want.ovf)
                    flag_mismatch($sformatf("overflow got %0b want %0b",
                                            got.ovf, want.ovf));
            end
            results_seen++;
        end
    end

    // Ends the run if no beat and no register write moves for too long.
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_ram.sv
hw/rtl/tcc_datapath.sv
hw/rtl/tcc_ctrl.sv
hw/rtl/trimmed_charge_centroid_top.sv
verif/tb_trimmed_charge_centroid_top.sv
